// ===== sv/nec_ir_frame_decoder_assert.svh =====
// Assertion macros for the NEC infrared frame decoder.
// Included by the top level; depends on nothing else.
`ifndef NEC_IR_FRAME_DECODER_ASSERT_SVH
`define NEC_IR_FRAME_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NECIR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("necir assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define NECIR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("necir assertion failed");

`endif

// ===== sv/necir_pkg.sv =====
// Shared types, constants and helpers for the NEC infrared frame decoder.
// Depends on nothing; used by necir_frame_core and nec_ir_frame_decoder.
`default_nettype none

package necir_pkg;

   localparam int INTERVAL_W     = 16;
   localparam int COMMAND_W      = 8;
   localparam int ADDRESS_W      = 8;
   localparam int CSR_INDEX_W    = 3;
   localparam int DATA_BITS      = 32;
   localparam int COUNT_W        = 6;
   localparam int CMD_FIRST_BIT  = 24;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_START_LOW      = 3'd0,
      REG_START_HIGH     = 3'd1,
      REG_ZERO_LOW       = 3'd2,
      REG_ZERO_HIGH      = 3'd3,
      REG_ONE_LOW        = 3'd4,
      REG_ONE_HIGH       = 3'd5,
      REG_DEVICE_ADDRESS = 3'd6
   } csr_index_type;

   localparam logic [INTERVAL_W-1:0] START_LOW_RESET  = 16'd2160;
   localparam logic [INTERVAL_W-1:0] START_HIGH_RESET = 16'd3240;
   localparam logic [INTERVAL_W-1:0] ONE_LOW_RESET    = 16'd360;
   localparam logic [INTERVAL_W-1:0] ONE_HIGH_RESET   = 16'd540;
   localparam logic [ADDRESS_W-1:0]  ADDRESS_RESET    = 8'd0;

   typedef struct packed {
      logic [INTERVAL_W-1:0] start_low;
      logic [INTERVAL_W-1:0] start_high;
      logic [INTERVAL_W-1:0] one_low;
      logic [INTERVAL_W-1:0] one_high;
      logic [ADDRESS_W-1:0]  device_address;
   } cfg_type;

   function automatic logic in_window(input logic [INTERVAL_W-1:0] v,
                                      input logic [INTERVAL_W-1:0] lo,
                                      input logic [INTERVAL_W-1:0] hi);
      return (lo < v) && (v < hi);
   endfunction

endpackage

`default_nettype wire

// ===== sv/nec_ir_frame_decoder.sv =====
// NEC infrared frame decoder.
// The block takes one falling-edge interval per item on the req_ channel; an item
// with req_frame_first set is the leader of a frame. The 32 intervals after it are
// data bits; after the last one a single item leaves on the rsp_ channel carrying
// the command byte, or zero if the leader was outside its window or the address
// did not match the configured device address. Other items give no result.
// An accepted item is registered, then processed by the frame logic into the
// result register; the item that completes a frame is processed only once the
// result register is empty or its result is taken. One item is taken per cycle,
// bounded only by the result register.
// When rsp_stall holds a result, items that give no result still pass; the item
// that would give the next result waits in the input register and req_stall rises.
// The csr_ port is always ready and sets the start and one windows and the device
// address; the user must use it only while the block is idle, which the block does
// not enforce. Synchronous reset restores the default windows, closes any open frame and empties both registers.
// Depends on necir_pkg, necir_frame_core and nec_ir_frame_decoder_assert.svh.
`default_nettype none

`include "nec_ir_frame_decoder_assert.svh"

module nec_ir_frame_decoder
   import necir_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [INTERVAL_W-1:0]  req_interval,
   input  wire logic                   req_frame_first,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [COMMAND_W-1:0]        rsp_command,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [INTERVAL_W-1:0]  csr_data
);

   cfg_type cfg_ff, cfg_in;

   logic                  s1_valid_ff, s1_valid_in;
   logic [INTERVAL_W-1:0] s1_interval_ff, s1_interval_in;
   logic                  s1_first_ff, s1_first_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COMMAND_W-1:0]  rsp_command_ff, rsp_command_in;

   logic                  req_accept;
   logic                  s1_fire;
   logic                  core_done;
   logic [COMMAND_W-1:0]  core_command;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            REG_START_LOW:      cfg_in.start_low      = csr_data;
            REG_START_HIGH:     cfg_in.start_high     = csr_data;
            REG_ONE_LOW:        cfg_in.one_low        = csr_data;
            REG_ONE_HIGH:       cfg_in.one_high       = csr_data;
            REG_DEVICE_ADDRESS: cfg_in.device_address = csr_data[ADDRESS_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   necir_frame_core u_core (
      .clock       (clock),
      .reset       (reset),
      .item_fire   (s1_fire),
      .interval    (s1_interval_ff),
      .frame_first (s1_first_ff),
      .cfg         (cfg_ff),
      .frame_done  (core_done),
      .command     (core_command)
   );

   assign s1_fire    = s1_valid_ff && (!core_done || !rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_fire;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      s1_valid_in    = s1_fire ? 1'b0 : s1_valid_ff;
      s1_interval_in = s1_interval_ff;
      s1_first_in    = s1_first_ff;
      if (req_accept) begin
         s1_valid_in    = 1'b1;
         s1_interval_in = req_interval;
         s1_first_in    = req_frame_first;
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_command_in = rsp_command_ff;
      if (s1_fire && core_done) begin
         rsp_valid_in   = 1'b1;
         rsp_command_in = core_command;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_command = rsp_command_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_low      <= START_LOW_RESET;
         cfg_ff.start_high     <= START_HIGH_RESET;
         cfg_ff.one_low        <= ONE_LOW_RESET;
         cfg_ff.one_high       <= ONE_HIGH_RESET;
         cfg_ff.device_address <= ADDRESS_RESET;
         s1_valid_ff           <= 1'b0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_interval_ff <= s1_interval_in;
      s1_first_ff    <= s1_first_in;
      rsp_command_ff <= rsp_command_in;
   end

   `NECIR_ASSERT_SAME(a_stall_needs_item, clock, reset, req_stall, s1_valid_ff)
   `NECIR_ASSERT_SAME(a_no_result_overwrite, clock, reset,
      s1_fire && core_done, !rsp_valid_ff || !rsp_stall)
   `NECIR_ASSERT_NEXT(a_result_registered, clock, reset,
      s1_fire && core_done, rsp_valid_ff)

endmodule

`default_nettype wire

// ===== sv/necir_frame_core.sv =====
// Frame state of the NEC decoder: leader check, bit classification and shifting.
// Depends on necir_pkg.
`default_nettype none

module necir_frame_core
   import necir_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  item_fire,
   input  wire logic [INTERVAL_W-1:0] interval,
   input  wire logic                  frame_first,
   input  wire cfg_type               cfg,
   output logic                       frame_done,
   output logic [COMMAND_W-1:0]       command
);

   localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(DATA_BITS);
   localparam logic [COUNT_W-1:0] ADDR_END   = COUNT_W'(ADDRESS_W);
   localparam logic [COUNT_W-1:0] CMD_START  = COUNT_W'(CMD_FIRST_BIT);

   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 leader_ff, leader_in;
   logic [ADDRESS_W-1:0] address_ff, address_in;
   logic [COMMAND_W-1:0] command_ff, command_in;
   logic [COUNT_W-1:0]   bit_index;
   logic                 data_bit;
   logic                 count_open;

   assign bit_index  = count_ff - COUNT_W'(1);
   assign data_bit   = in_window(interval, cfg.one_low, cfg.one_high);
   assign count_open = (count_ff != '0) && (count_ff <= LAST_COUNT);
   assign frame_done = !frame_first && (count_ff == LAST_COUNT);
   assign command    = (leader_ff && (address_ff == cfg.device_address))
                       ? {command_ff[COMMAND_W-2:0], data_bit} : '0;

   always_comb begin
      count_in   = count_ff;
      leader_in  = leader_ff;
      address_in = address_ff;
      command_in = command_ff;
      if (item_fire) begin
         if (frame_first) begin
            leader_in  = in_window(interval, cfg.start_low, cfg.start_high);
            address_in = '0;
            command_in = '0;
            count_in   = COUNT_W'(1);
         end else if (!count_open) begin
            count_in = '0;
         end else begin
            if (bit_index < ADDR_END) begin
               address_in = {address_ff[ADDRESS_W-2:0], data_bit};
            end else if (bit_index >= CMD_START) begin
               command_in = {command_ff[COMMAND_W-2:0], data_bit};
            end
            count_in = (count_ff == LAST_COUNT) ? '0 : count_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         leader_ff  <= 1'b0;
         address_ff <= '0;
         command_ff <= '0;
      end else begin
         count_ff   <= count_in;
         leader_ff  <= leader_in;
         address_ff <= address_in;
         command_ff <= command_in;
      end
   end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for nec_ir_frame_decoder: directed frames, then random
// phases under several window settings with random idling on both channels.
// Depends on necir_pkg and the decoder RTL only.

module testbench;
   import necir_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 3'd7;
   localparam logic [INTERVAL_W-1:0] ZERO_LOW_RESET  = 16'd180;
   localparam logic [INTERVAL_W-1:0] ZERO_HIGH_RESET = 16'd270;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 170;
   localparam int LONG_HOLD     = 400;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [INTERVAL_W-1:0] start_low;
      logic [INTERVAL_W-1:0] start_high;
      logic [INTERVAL_W-1:0] zero_low;
      logic [INTERVAL_W-1:0] zero_high;
      logic [INTERVAL_W-1:0] one_low;
      logic [INTERVAL_W-1:0] one_high;
      logic [INTERVAL_W-1:0] device_address;
   } window_set_type;

   typedef struct packed {
      logic                  has_leader;
      logic [INTERVAL_W-1:0] leader;
      logic [5:0]            nbits;
      logic [31:0]           bits;
      logic [INTERVAL_W-1:0] one_iv;
      logic [INTERVAL_W-1:0] zero_iv;
      logic                  typed;
      logic [COMMAND_W-1:0]  cmd;
   } frame_row_type;

   localparam int ROWS = 18;
   localparam frame_row_type DIRECTED_FRAMES [ROWS] = '{
      '{1'b0, 16'd0,     6'd3,  32'h0000_0000, 16'd450, 16'd225,   1'b0, 8'h00},
      '{1'b1, 16'd2700,  6'd32, 32'h00FF_5AA5, 16'd450, 16'd225,   1'b1, 8'hA5},
      '{1'b1, 16'd2160,  6'd32, 32'h00FF_C33C, 16'd450, 16'd225,   1'b1, 8'h00},
      '{1'b1, 16'd3240,  6'd32, 32'h00FF_C33C, 16'd450, 16'd225,   1'b1, 8'h00},
      '{1'b1, 16'd2161,  6'd32, 32'h00FF_00FF, 16'd450, 16'd225,   1'b1, 8'hFF},
      '{1'b1, 16'd3239,  6'd32, 32'h00FF_FE01, 16'd450, 16'd225,   1'b1, 8'h01},
      '{1'b1, 16'd0,     6'd32, 32'h00FF_F00F, 16'd450, 16'd225,   1'b1, 8'h00},
      '{1'b1, 16'd65535, 6'd32, 32'h00FF_F00F, 16'd450, 16'd225,   1'b1, 8'h00},
      '{1'b1, 16'd2700,  6'd32, 32'h807F_8877, 16'd450, 16'd225,   1'b1, 8'h00},
      '{1'b1, 16'd2700,  6'd12, 32'hFFFF_FFFF, 16'd450, 16'd225,   1'b0, 8'h00},
      '{1'b1, 16'd2700,  6'd32, 32'h00FF_BD42, 16'd450, 16'd225,   1'b1, 8'h42},
      '{1'b1, 16'd2700,  6'd32, 32'hFFFF_FFFF, 16'd360, 16'd0,     1'b1, 8'h00},
      '{1'b1, 16'd2700,  6'd32, 32'hFFFF_FFFF, 16'd540, 16'd65535, 1'b1, 8'h00},
      '{1'b1, 16'd2700,  6'd32, 32'h00FF_3CC3, 16'd361, 16'd270,   1'b1, 8'hC3},
      '{1'b1, 16'd2700,  6'd32, 32'h00FF_C33C, 16'd539, 16'd181,   1'b1, 8'h3C},
      '{1'b0, 16'd0,     6'd2,  32'h0000_0000, 16'd450, 16'd225,   1'b0, 8'h00},
      '{1'b1, 16'd2700,  6'd31, 32'h00FF_6699, 16'd450, 16'd225,   1'b0, 8'h00},
      '{1'b1, 16'd2700,  6'd32, 32'h00FF_6699, 16'd450, 16'd225,   1'b1, 8'h99}
   };

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [INTERVAL_W-1:0]  req_interval;
   logic                   req_frame_first;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [COMMAND_W-1:0]   rsp_command;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [INTERVAL_W-1:0]  csr_data;

   window_set_type       win;
   logic [5:0]           frame_pos;
   logic                 leader_ok;
   logic [7:0]           addr_bits;
   logic [7:0]           cmd_bits;
   logic [COMMAND_W-1:0] expected_commands [$];
   logic [COMMAND_W-1:0] want_cmd;

   int  errors = 0;
   int  items_sent = 0;
   int  commands_checked = 0;
   int  settings_used = 0;
   bit  idling_on = 1'b1;
   bit  long_hold_req = 1'b0;

   nec_ir_frame_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_interval    (req_interval),
      .req_frame_first (req_frame_first),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_command     (rsp_command),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   // Advances the decoder state by one interval; returns 1 when a frame completes.
   function automatic logic frame_decode(input logic [INTERVAL_W-1:0] iv, input logic first,
                                         output logic [COMMAND_W-1:0] cmd);
      logic bit_val;
      cmd = '0;
      if (first) begin
         leader_ok = (win.start_low < iv) && (iv < win.start_high);
         addr_bits = '0;
         cmd_bits  = '0;
         frame_pos = 6'd1;
         return 1'b0;
      end
      if (frame_pos == 6'd0 || frame_pos > DATA_BITS) begin
         frame_pos = 6'd0;
         return 1'b0;
      end
      bit_val = (win.one_low < iv) && (iv < win.one_high);
      if (frame_pos <= 6'd8) begin
         addr_bits = {addr_bits[6:0], bit_val};
      end else if (frame_pos > CMD_FIRST_BIT) begin
         cmd_bits = {cmd_bits[6:0], bit_val};
      end
      frame_pos = frame_pos + 6'd1;
      if (frame_pos <= DATA_BITS) return 1'b0;
      frame_pos = 6'd0;
      cmd = (leader_ok && addr_bits == win.device_address[7:0]) ? cmd_bits : 8'h00;
      return 1'b1;
   endfunction

   function automatic logic [INTERVAL_W-1:0] pick_interval(input logic [INTERVAL_W-1:0] lo,
                                                          input logic [INTERVAL_W-1:0] hi);
      case ($urandom_range(0, 11))
         0: return lo;
         1: return hi;
         2: return lo + 16'd1;
         3: return hi - 16'd1;
         4: return 16'($urandom_range(0, 65535));
         5: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: begin
            if (int'(hi) > int'(lo) + 1) return 16'($urandom_range(int'(lo) + 1, int'(hi) - 1));
            return 16'($urandom_range(0, 65535));
         end
      endcase
   endfunction

   function automatic window_set_type pick_setting(input int phase);
      window_set_type s;
      logic [INTERVAL_W-1:0] lo;
      s = '{START_LOW_RESET, START_HIGH_RESET, ZERO_LOW_RESET, ZERO_HIGH_RESET,
            ONE_LOW_RESET, ONE_HIGH_RESET, 16'h00FF};
      case (phase)
         0: ;
         1: s = '0;
         2: s = '1;
         3: s = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF,
                  16'($urandom_range(0, 65535))};
         4: s = '{16'd1000, 16'd2000, 16'd100, 16'd500, 16'd300, 16'd700,
                  16'($urandom_range(0, 255))};
         default: begin
            lo = 16'($urandom_range(0, 60000));
            s.start_low  = lo;
            s.start_high = lo + 16'($urandom_range(0, 5000));
            lo = 16'($urandom_range(0, 60000));
            s.zero_low   = lo;
            s.zero_high  = lo + 16'($urandom_range(0, 3000));
            lo = 16'($urandom_range(0, 60000));
            s.one_low    = lo;
            s.one_high   = lo + 16'($urandom_range(0, 3000));
            s.device_address = 16'($urandom_range(0, 65535));
            if ($urandom_range(0, 3) == 0) s.one_high = 16'($urandom_range(0, 65535));
         end
      endcase
      return s;
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [INTERVAL_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_START_LOW:      win.start_low = data;
         REG_START_HIGH:     win.start_high = data;
         REG_ZERO_LOW:       win.zero_low = data;
         REG_ZERO_HIGH:      win.zero_high = data;
         REG_ONE_LOW:        win.one_low = data;
         REG_ONE_HIGH:       win.one_high = data;
         REG_DEVICE_ADDRESS: win.device_address = {8'h00, data[7:0]};
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input window_set_type s);
      write_reg(REG_START_LOW, s.start_low);
      write_reg(REG_START_HIGH, s.start_high);
      write_reg(REG_ZERO_LOW, s.zero_low);
      write_reg(REG_ZERO_HIGH, s.zero_high);
      write_reg(REG_ONE_LOW, s.one_low);
      write_reg(REG_ONE_HIGH, s.one_high);
      write_reg(REG_DEVICE_ADDRESS, s.device_address);
      write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
      settings_used++;
   endtask

   task automatic send_interval(input logic [INTERVAL_W-1:0] iv, input logic first,
                                input logic typed, input logic [COMMAND_W-1:0] typed_cmd);
      logic [COMMAND_W-1:0] cmd;
      logic                 ignored;
      if (idling_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_interval    <= iv;
      req_frame_first <= first;
      do @(posedge clock); while (req_stall);
      ignored = !first && frame_pos == 6'd0;
      if (!ignored) items_sent++;
      if (frame_decode(iv, first, cmd)) expected_commands.push_back(typed ? typed_cmd : cmd);
   endtask

   task automatic send_row(input frame_row_type row);
      if (row.has_leader) send_interval(row.leader, 1'b1, row.typed, row.cmd);
      for (int i = 0; i < int'(row.nbits); i++) begin
         send_interval(row.bits[31 - i] ? row.one_iv : row.zero_iv, 1'b0, row.typed, row.cmd);
      end
   endtask

   task automatic send_random_frame(input int nbits);
      logic [31:0] bits;
      bits = $urandom;
      if ($urandom_range(0, 9) < 7) bits[31:24] = win.device_address[7:0];
      send_interval(pick_interval(win.start_low, win.start_high), 1'b1, 1'b0, 8'h00);
      for (int i = 0; i < nbits; i++) begin
         send_interval(bits[31 - i] ? pick_interval(win.one_low, win.one_high)
                                    : pick_interval(win.zero_low, win.zero_high),
                       1'b0, 1'b0, 8'h00);
      end
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (expected_commands.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_commands.size() == 0) begin
            $error("command: expected none, actual %0h", rsp_command);
            errors++;
         end else begin
            want_cmd = expected_commands.pop_front();
            if (rsp_command !== want_cmd) begin
               $error("command: expected %0h, actual %0h", want_cmd, rsp_command);
               errors++;
            end
         end
         commands_checked++;
      end
   end

   initial begin
      int phase_items;
      int pick;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_interval    = '0;
      req_frame_first = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      win = '{START_LOW_RESET, START_HIGH_RESET, ZERO_LOW_RESET, ZERO_HIGH_RESET,
              ONE_LOW_RESET, ONE_HIGH_RESET, {8'h00, ADDRESS_RESET}};
      frame_pos = '0;
      leader_ok = 1'b0;
      addr_bits = '0;
      cmd_bits  = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < ROWS; r++) send_row(DIRECTED_FRAMES[r]);
      drain();

      for (int phase = 0; phase < PHASES; phase++) begin
         apply_setting(pick_setting(phase));
         if (phase == PHASES - 1) idling_on = 1'b0;
         if (phase == 5) long_hold_req = 1'b1;
         phase_items = items_sent;
         while (items_sent - phase_items < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 8 && frame_pos == 6'd0) begin
               repeat ($urandom_range(1, 3)) begin
                  send_interval(16'($urandom_range(0, 65535)), 1'b0, 1'b0, 8'h00);
               end
            end else if (pick < 20) begin
               send_random_frame($urandom_range(0, 31));
            end else begin
               send_random_frame(DATA_BITS);
            end
         end
         drain();
      end

      $display("Run covered %0d intervals and %0d commands under %0d window settings.",
               items_sent, commands_checked, settings_used);
      if (errors == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
